// ===== src/lasm_pkg.sv =====
`timescale 1ns / 1ps

package lasm_pkg;

  // Default number of characters the line store holds.
  localparam int DEF_LINE_CAPACITY = 64;

  // Width and reset value of the out_size register.
  localparam int             OUT_SIZE_W     = 7;
  localparam logic [6:0]     OUT_SIZE_RESET = 7'd65;

  // Packed stream widths.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Character codes the framer reacts to.
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Input command codes.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_FLUSH
  } lasm_state_t;

endpackage

// ===== src/line_assembler_with_overflow_skip_top.sv =====
`timescale 1ns / 1ps

// Line framer for received serial bytes. Each input word carries a command
// bit and a byte; ordinary bytes are gathered into a line store of
// LINE_CAPACITY characters, carriage returns are dropped, and a newline ends
// the line. A byte that would overflow the store discards the partial line
// and the block then ignores bytes up to the next newline; a drain command
// does the same at once. A newline that ends a skip, or an empty line, is
// swallowed. Otherwise the stored characters come out one word each, at most
// out_size-1 of them and stopping before the first zero byte, with tlast on
// the final one; a line that comes out with no characters gives a single word
// with tuser set (the empty flag) and tlast set. Timing: bytes, carriage
// returns, drains and swallowed newlines are taken while idle. A newline that
// delivers a line holds the input off until its last word is handed on: the
// store's single read port gives one character a cycle while the output is
// not stalled, and the last one then leaves the one-character lookahead register.
// When a zero byte ends the line early, its read still takes place before the
// input is released. A line that out_size cuts to nothing holds the input off
// while its empty word is handed on. Output stalls also hold the input off.
// A result waiting in the output register does not block new input bytes.
// out_size is written through the cfg port; the user must write it only while no
// line is being delivered, which the block does not enforce; its reset value is 65.

module line_assembler_with_overflow_skip_top
  import lasm_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] command, [8:1] rx_byte, [15:9] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] char_value
  output logic                   out_tlast,
  output logic                   out_tuser,  // [0] empty_line
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [OUT_SIZE_W-1:0]  cfg_data
);

  // Store address and fill count widths follow from the capacity.
  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int CW = $clog2(LINE_CAPACITY + 1);

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_wdata;
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;

  lasm_ctrl #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .AW            (AW),
    .CW            (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_re      (st_re),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata)
  );

  lasm_store #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .AW            (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule

// ===== src/lasm_store.sv =====
`timescale 1ns / 1ps

module lasm_store
  import lasm_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
  parameter int AW            = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [LINE_CAPACITY];
  logic [7:0] rdata_r;

  // Single write port and one registered read port; read data holds while
  // no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lasm_ctrl.sv =====
`timescale 1ns / 1ps

module lasm_ctrl
  import lasm_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
  parameter int AW            = 6,
  parameter int CW            = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [OUT_SIZE_W-1:0]  cfg_data,
  output logic                   st_we,
  output logic [AW-1:0]          st_waddr,
  output logic [7:0]             st_wdata,
  output logic                   st_re,
  output logic [AW-1:0]          st_raddr,
  input  logic [7:0]             st_rdata
);

  localparam int EW  = (CW > OUT_SIZE_W) ? CW : OUT_SIZE_W;
  localparam int CW1 = CW + 1;

  lasm_state_t           state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic                  skip_r, skip_nxt;
  logic [OUT_SIZE_W-1:0] out_size_r;
  logic [CW-1:0]         end_r, end_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  data_vld_r, data_vld_nxt;
  logic [7:0]            pend_r, pend_nxt;
  logic                  have_pend_r, have_pend_nxt;
  logic                  out_valid_r;
  logic [7:0]            out_char_r;
  logic                  out_last_r;
  logic                  out_empty_r;

  logic                  in_acc;
  logic                  cmd;
  logic [7:0]            rx_byte;
  logic                  out_free;
  logic [OUT_SIZE_W-1:0] limit;
  logic [EW-1:0]         fill_ext, lim_ext, end_sel;
  logic [CW-1:0]         end_calc;
  logic [CW1-1:0]        nxt_idx;
  logic                  last_idx;
  logic                  emit;
  logic [7:0]            emit_char;
  logic                  emit_last;
  logic                  emit_empty;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cmd        = in_tdata[0];
  assign rx_byte    = in_tdata[8:1];
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;

  // Character limit is out_size minus one, never below zero, and never
  // more than what is stored.
  assign limit    = (out_size_r == '0) ? '0 : out_size_r - 1'b1;
  assign fill_ext = EW'(fill_r);
  assign lim_ext  = EW'(limit);
  assign end_sel  = (lim_ext < fill_ext) ? lim_ext : fill_ext;
  assign end_calc = CW'(end_sel);

  assign nxt_idx  = CW1'(rd_idx_r) + 1'b1;
  assign last_idx = (nxt_idx == CW1'(end_r));

  assign st_waddr = fill_r[AW-1:0];
  assign st_wdata = rx_byte;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    skip_nxt      = skip_r;
    end_nxt       = end_r;
    rd_idx_nxt    = rd_idx_r;
    data_vld_nxt  = data_vld_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    st_we         = 1'b0;
    st_re         = 1'b0;
    st_raddr      = '0;
    emit          = 1'b0;
    emit_char     = CHAR_NUL;
    emit_last     = 1'b0;
    emit_empty    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd == CMD_DRAIN) begin
            fill_nxt = '0;
            skip_nxt = 1'b1;
          end else if (rx_byte == CHAR_LF) begin
            skip_nxt = 1'b0;
            fill_nxt = '0;
            if (!skip_r && (fill_r != '0)) begin
              end_nxt       = end_calc;
              have_pend_nxt = 1'b0;
              if (end_calc == '0) begin
                state_nxt = S_FLUSH;
              end else begin
                st_re        = 1'b1;
                st_raddr     = '0;
                rd_idx_nxt   = '0;
                data_vld_nxt = 1'b1;
                state_nxt    = S_EMIT;
              end
            end
          end else if ((rx_byte == CHAR_CR) || skip_r) begin
            // Dropped.
          end else if (fill_r == CW'(LINE_CAPACITY)) begin
            skip_nxt = 1'b1;
            fill_nxt = '0;
          end else begin
            st_we    = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
      end

      S_EMIT: begin
        // Each character is held back one read so that the next one tells
        // whether it ends the line.
        if (data_vld_r && out_free) begin
          data_vld_nxt = 1'b0;
          if (st_rdata == CHAR_NUL) begin
            state_nxt = S_FLUSH;
          end else begin
            if (have_pend_r) begin
              emit      = 1'b1;
              emit_char = pend_r;
            end
            pend_nxt      = st_rdata;
            have_pend_nxt = 1'b1;
            if (last_idx) begin
              state_nxt = S_FLUSH;
            end else begin
              st_re        = 1'b1;
              st_raddr     = nxt_idx[AW-1:0];
              rd_idx_nxt   = nxt_idx[AW-1:0];
              data_vld_nxt = 1'b1;
            end
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_char  = have_pend_r ? pend_r : CHAR_NUL;
          emit_last  = 1'b1;
          emit_empty = !have_pend_r;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      skip_r      <= 1'b0;
      out_size_r  <= OUT_SIZE_RESET;
      data_vld_r  <= 1'b0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      skip_r      <= skip_nxt;
      data_vld_r  <= data_vld_nxt;
      have_pend_r <= have_pend_nxt;
      if (cfg_valid && cfg_ready) begin
        out_size_r <= cfg_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_r    <= end_nxt;
    rd_idx_r <= rd_idx_nxt;
    pend_r   <= pend_nxt;
    if (emit) begin
      out_char_r  <= emit_char;
      out_last_r  <= emit_last;
      out_empty_r <= emit_empty;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(LINE_CAPACITY))
    else $error("fill count exceeds line capacity");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (CW'(rd_idx_r) < end_r))
    else $error("store read beyond end of line");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("empty line word not marked last");

  a_read_state: assert property (@(posedge clk) disable iff (!rst_n)
    data_vld_r |-> (state_r == S_EMIT))
    else $error("read data pending outside emit");

  a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FLUSH) && out_free) |=> (state_r == S_IDLE) && out_valid_r && out_last_r)
    else $error("flush did not close the line");
`endif

endmodule
